// ===== design/ptwhc_pkg.sv =====
// ============================================================================
// ptwhc_pkg: shared types and constants for hit clustering
// Holds the request/response structs, the per-cluster record and the divide
// and square-root requests used by the cluster engine and its helper units.
// ============================================================================
`timescale 1ns / 1ps

package ptwhc_pkg;

   localparam int DEF_CHANNELS     = 512;
   localparam int DEF_CLUSTERS     = 8;
   localparam int WINDOW_W         = 16;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd64;
   localparam logic [7:0] COUNT_MAX = 8'd255;

   localparam logic CMD_HIT   = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [8:0]  channel;
      logic [15:0] hit_time;
      logic [15:0] hit_energy;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
   } req_type;

   typedef struct packed {
      logic [8:0]  out_channel;
      logic [15:0] mean_time;
      logic [15:0] time_spread;
      logic [23:0] energy_total;
      logic signed [15:0] mean_x;
      logic signed [15:0] mean_y;
      logic signed [15:0] mean_z;
      logic [7:0]  hit_count;
      logic [7:0]  dropped_hits;
      logic        last;
   } rsp_type;

   // one cluster record, one memory word
   typedef struct packed {
      logic [23:0] esum;
      logic [39:0] tsum;
      logic [55:0] t2sum;
      logic signed [39:0] xsum;
      logic signed [39:0] ysum;
      logic signed [39:0] zsum;
      logic [7:0]  hits;
   } clu_type;

   // divide unit request: unsigned magnitudes
   typedef struct packed {
      logic        start;
      logic [55:0] dividend;
      logic [23:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        start;
      logic [55:0] radicand;
   } sqrt_req_type;

endpackage

// ===== design/ptwhc_div.sv =====
// ============================================================================
// ptwhc_div: restoring divider
// Unsigned 56 by 24 bit division, one quotient bit per cycle.
// ============================================================================
`timescale 1ns / 1ps

module ptwhc_div (
   input  logic                   clock,
   input  logic                   reset,
   input  ptwhc_pkg::div_req_type div_req,
   output logic                   done,
   output logic [55:0]            quotient
);
   import ptwhc_pkg::*;

   logic [55:0] quo_ff, quo_in;
   logic [24:0] rem_ff, rem_in;
   logic [23:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [24:0] trial;
   logic [25:0] diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[23:0], quo_ff[55]};
      diff    = {1'b0, trial} - {2'b00, dvs_ff};
      if (div_req.start) begin
         quo_in = div_req.dividend;
         rem_in = '0;
         dvs_in = div_req.divisor;
         cnt_in = 6'd55;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[25]) begin
            rem_in = diff[24:0];
            quo_in = {quo_ff[54:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[54:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== design/ptwhc_sqrt.sv =====
// ============================================================================
// ptwhc_sqrt: digit-by-digit square root
// Floor square root of a 56 bit value, one result bit per cycle.
// ============================================================================
`timescale 1ns / 1ps

module ptwhc_sqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  ptwhc_pkg::sqrt_req_type sqrt_req,
   output logic                    done,
   output logic [27:0]             root
);
   import ptwhc_pkg::*;

   logic [55:0] rad_ff, rad_in;
   logic [29:0] rem_ff, rem_in;
   logic [27:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [29:0] trial;
   logic [30:0] diff;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[27:0], rad_ff[55:54]};
      diff    = {1'b0, trial} - {1'b0, root_ff, 2'b01};
      if (sqrt_req.start) begin
         rad_in  = sqrt_req.radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 5'd27;
         run_in  = 1'b1;
      end else if (run_ff) begin
         rad_in = {rad_ff[53:0], 2'b00};
         if (!diff[30]) begin
            rem_in  = diff[29:0];
            root_in = {root_ff[26:0], 1'b1};
         end else begin
            rem_in  = trial;
            root_in = {root_ff[26:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== design/per_channel_time_window_hit_clustering.sv =====
// ============================================================================
// per_channel_time_window_hit_clustering: per-channel time-window clustering
// hit: directory read, read and compare each cluster in turn, then merge, open or drop
// drain: five divides and one square root per cluster
// one request at a time; reset runs a clear of every directory entry, busy high
// ============================================================================
`timescale 1ns / 1ps

module per_channel_time_window_hit_clustering #(
   parameter int CHANNELS             = ptwhc_pkg::DEF_CHANNELS,
   parameter int CLUSTERS_PER_CHANNEL = ptwhc_pkg::DEF_CLUSTERS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  ptwhc_pkg::req_type  req_data,
   output logic                rsp_strobe,
   output ptwhc_pkg::rsp_type  rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [15:0]         csr_data
);
   import ptwhc_pkg::*;

   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CL_W   = (CLUSTERS_PER_CHANNEL > 1) ? $clog2(CLUSTERS_PER_CHANNEL) : 1;
   localparam int CNT_W  = $clog2(CLUSTERS_PER_CHANNEL + 1);
   localparam int SLOT_W = CH_W + CL_W;
   localparam int SLOTS  = CHANNELS * (1 << CL_W);
   localparam int DIR_W  = CNT_W + 8;

   typedef enum logic [14:0] {
      ST_CLEAR   = 15'b000000000000001,
      ST_IDLE    = 15'b000000000000010,
      ST_DIRRD   = 15'b000000000000100,
      ST_DIRWAIT = 15'b000000000001000,
      ST_RD      = 15'b000000000010000,
      ST_CMP     = 15'b000000000100000,
      ST_MUL     = 15'b000000001000000,
      ST_WR      = 15'b000000010000000,
      ST_DRD     = 15'b000000100000000,
      ST_DLOAD   = 15'b000001000000000,
      ST_DIVT    = 15'b000010000000000,
      ST_DIVX    = 15'b000100000000000,
      ST_DIVY    = 15'b001000000000000,
      ST_DIVZ    = 15'b010000000000000,
      ST_DQ      = 15'b100000000000000
   } state_type;

   state_type   state_ff, state_in;
   logic [15:0] window_ff;

   // memories
   clu_type          clu_mem [SLOTS];
   logic [DIR_W-1:0] dir_mem [CHANNELS];
   clu_type          clu_rd_ff;
   logic [DIR_W-1:0] dir_rd_ff;
   logic             clu_we, dir_we;
   logic [SLOT_W-1:0] clu_waddr, clu_raddr;
   clu_type          clu_wdata;
   logic [CH_W-1:0]  dir_addr;
   logic [DIR_W-1:0] dir_wdata;

   req_type          req_ff;
   logic [CH_W-1:0]  clr_ff;
   logic [CNT_W-1:0] n_ff;
   logic [7:0]       drop_ff;
   logic [CNT_W-1:0] k_ff;
   logic             sq_ff;
   logic [15:0]      mt_ff;
   logic [39:0]      wmag;
   rsp_type          out_ff;
   logic             strobe_ff;

   // merge products
   logic [31:0] et_ff;
   logic [47:0] ett_ff;
   logic signed [31:0] ex_ff, ey_ff, ez_ff;

   div_req_type  dreq;
   sqrt_req_type sreq;
   logic         ddone, sdone;
   logic [55:0]  dquo;
   logic [27:0]  sroot;

   ptwhc_div u_div (.clock(clock), .reset(reset), .div_req(dreq), .done(ddone),
                    .quotient(dquo));
   ptwhc_sqrt u_sqrt (.clock(clock), .reset(reset), .sqrt_req(sreq), .done(sdone),
                      .root(sroot));

   logic in_range;
   logic [SLOT_W-1:0] slot;
   logic [39:0] te, diffv;
   logic [39:0] wce;
   logic [31:0] m2;

   assign in_range = ({23'd0, req_data.channel} < 32'(CHANNELS));
   assign slot     = {req_ff.channel[CH_W-1:0], k_ff[CL_W-1:0]};
   assign te       = 40'(req_ff.hit_time) * 40'(clu_rd_ff.esum);
   assign diffv    = (clu_rd_ff.tsum >= te) ? clu_rd_ff.tsum - te : te - clu_rd_ff.tsum;
   assign wce      = 40'(window_ff) * 40'(clu_rd_ff.esum);
   assign m2       = 32'(mt_ff) * 32'(mt_ff);

   always_comb begin
      state_in  = state_ff;
      clu_we    = 1'b0;
      dir_we    = 1'b0;
      clu_waddr = slot;
      clu_raddr = slot;
      clu_wdata = clu_rd_ff;
      dir_addr  = req_ff.channel[CH_W-1:0];
      dir_wdata = {n_ff, drop_ff};
      dreq      = '0;
      sreq      = '0;
      wmag      = '0;
      case (state_ff)
         ST_CLEAR: begin
            dir_we    = 1'b1;
            dir_addr  = clr_ff;
            dir_wdata = '0;
            if (32'(clr_ff) == CHANNELS - 1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start && in_range && !(req_data.cmd == CMD_HIT && req_data.hit_energy == '0))
               state_in = ST_DIRRD;
         end
         ST_DIRRD:   state_in = ST_DIRWAIT;
         ST_DIRWAIT: state_in = (req_ff.cmd == CMD_HIT) ? ST_RD : ST_DRD;
         ST_RD: begin
            if (k_ff == n_ff) begin
               if (32'(n_ff) >= CLUSTERS_PER_CHANNEL) begin
                  dir_we    = 1'b1;
                  dir_wdata = {n_ff, (drop_ff == COUNT_MAX) ? drop_ff : drop_ff + 8'd1};
                  state_in  = ST_IDLE;
               end else begin
                  state_in = ST_MUL;
               end
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (diffv < wce) begin
               if (clu_rd_ff.hits == COUNT_MAX) begin
                  dir_we    = 1'b1;
                  dir_wdata = {n_ff, (drop_ff == COUNT_MAX) ? drop_ff : drop_ff + 8'd1};
                  state_in  = ST_IDLE;
               end else begin
                  state_in = ST_MUL;
               end
            end else begin
               state_in = ST_RD;
            end
         end
         ST_MUL: state_in = ST_WR;
         ST_WR: begin
            clu_we = 1'b1;
            if (k_ff == n_ff) begin
               clu_wdata.esum  = 24'(req_ff.hit_energy);
               clu_wdata.tsum  = 40'(et_ff);
               clu_wdata.t2sum = 56'(ett_ff);
               clu_wdata.xsum  = 40'(ex_ff);
               clu_wdata.ysum  = 40'(ey_ff);
               clu_wdata.zsum  = 40'(ez_ff);
               clu_wdata.hits  = 8'd1;
               dir_we    = 1'b1;
               dir_wdata = {n_ff + CNT_W'(1), drop_ff};
            end else begin
               clu_wdata.esum  = clu_rd_ff.esum + 24'(req_ff.hit_energy);
               clu_wdata.tsum  = clu_rd_ff.tsum + 40'(et_ff);
               clu_wdata.t2sum = clu_rd_ff.t2sum + 56'(ett_ff);
               clu_wdata.xsum  = clu_rd_ff.xsum + 40'(ex_ff);
               clu_wdata.ysum  = clu_rd_ff.ysum + 40'(ey_ff);
               clu_wdata.zsum  = clu_rd_ff.zsum + 40'(ez_ff);
               clu_wdata.hits  = clu_rd_ff.hits + 8'd1;
            end
            state_in = ST_IDLE;
         end
         ST_DRD: begin
            if (k_ff == n_ff) begin
               dir_we    = 1'b1;
               dir_wdata = '0;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_DLOAD;
            end
         end
         ST_DLOAD: begin
            dreq.start    = 1'b1;
            dreq.dividend = 56'(clu_rd_ff.tsum);
            dreq.divisor  = clu_rd_ff.esum;
            state_in      = ST_DIVT;
         end
         ST_DIVT: begin
            if (ddone) begin
               wmag = clu_rd_ff.xsum[39] ? 40'(-clu_rd_ff.xsum) : clu_rd_ff.xsum;
               dreq.start    = 1'b1;
               dreq.dividend = 56'(wmag);
               dreq.divisor  = clu_rd_ff.esum;
               state_in      = ST_DIVX;
            end
         end
         ST_DIVX: begin
            if (ddone) begin
               wmag = clu_rd_ff.ysum[39] ? 40'(-clu_rd_ff.ysum) : clu_rd_ff.ysum;
               dreq.start    = 1'b1;
               dreq.dividend = 56'(wmag);
               dreq.divisor  = clu_rd_ff.esum;
               state_in      = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (ddone) begin
               wmag = clu_rd_ff.zsum[39] ? 40'(-clu_rd_ff.zsum) : clu_rd_ff.zsum;
               dreq.start    = 1'b1;
               dreq.dividend = 56'(wmag);
               dreq.divisor  = clu_rd_ff.esum;
               state_in      = ST_DIVZ;
            end
         end
         ST_DIVZ: begin
            if (ddone) begin
               dreq.start    = 1'b1;
               dreq.dividend = clu_rd_ff.t2sum;
               dreq.divisor  = clu_rd_ff.esum;
               state_in      = ST_DQ;
            end
         end
         ST_DQ: begin
            // q - mt^2, then square root; sq_ff marks the start of the root phase
            if (ddone) begin
               sreq.start    = 1'b1;
               sreq.radicand = (dquo > 56'(m2)) ? dquo - 56'(m2) : '0;
            end
            if (sdone) state_in = ST_DRD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (clu_we) clu_mem[clu_waddr] <= clu_wdata;
      clu_rd_ff <= clu_mem[clu_raddr];
      if (dir_we) dir_mem[dir_addr] <= dir_wdata;
      dir_rd_ff <= dir_mem[dir_addr];
   end

   always_ff @(posedge clock) begin
      et_ff  <= 32'(req_ff.hit_energy) * 32'(req_ff.hit_time);
      ett_ff <= 48'(et_ff) * 48'(req_ff.hit_time);
      ex_ff  <= 32'($signed({1'b0, req_ff.hit_energy})) * 32'(req_ff.pos_x);
      ey_ff  <= 32'($signed({1'b0, req_ff.hit_energy})) * 32'(req_ff.pos_y);
      ez_ff  <= 32'($signed({1'b0, req_ff.hit_energy})) * 32'(req_ff.pos_z);
      if (state_ff == ST_IDLE) req_ff <= req_data;
      if (state_ff == ST_DIRWAIT) begin
         n_ff    <= dir_rd_ff[DIR_W-1:8];
         drop_ff <= dir_rd_ff[7:0];
      end
      if (ddone) begin
         case (state_ff)
            ST_DIVT: mt_ff <= dquo[15:0];
            ST_DIVX: out_ff.mean_x <= clu_rd_ff.xsum[39] ? -dquo[15:0] : dquo[15:0];
            ST_DIVY: out_ff.mean_y <= clu_rd_ff.ysum[39] ? -dquo[15:0] : dquo[15:0];
            ST_DIVZ: out_ff.mean_z <= clu_rd_ff.zsum[39] ? -dquo[15:0] : dquo[15:0];
            default: ;
         endcase
      end
      if (state_ff == ST_DQ && sdone) begin
         out_ff.out_channel  <= req_ff.channel;
         out_ff.mean_time    <= mt_ff;
         out_ff.time_spread  <= (clu_rd_ff.hits > 8'd1) ? sroot[15:0] : 16'd0;
         out_ff.energy_total <= clu_rd_ff.esum;
         out_ff.hit_count    <= clu_rd_ff.hits;
         out_ff.dropped_hits <= drop_ff;
         out_ff.last         <= (k_ff + CNT_W'(1) == n_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         window_ff <= WINDOW_RESET;
         k_ff      <= '0;
         sq_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= (state_ff == ST_DQ) && sdone;
         sq_ff     <= (state_ff == ST_DQ) && ddone;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + CH_W'(1);
         if (csr_valid && csr_ready) window_ff <= csr_data;
         if (state_ff == ST_DIRWAIT) k_ff <= '0;
         else if (state_ff == ST_CMP && !(diffv < wce)) k_ff <= k_ff + CNT_W'(1);
         else if (state_ff == ST_DQ && sdone) k_ff <= k_ff + CNT_W'(1);
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = out_ff;

`ifndef SYNTHESIS
   a_strobe_after_root: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(sdone)) else $error("result without root");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start && in_range && req_data.hit_energy != 16'd0)
      |=> busy) else $error("request not taken");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (k_ff < n_ff)) else $error("search past table");
   a_root_after_div: assert property (@(posedge clock) disable iff (reset)
      sq_ff |-> (state_ff == ST_DQ)) else $error("root phase outside drain");
`endif

endmodule
